FILE: rtl/cnh_pkg.sv
package cnh_pkg;

   // Geometry limits and storage sizes
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int DIM_W      = 11;
   localparam int ROW_W      = 11;
   localparam int BANKS      = 3;

   localparam logic [DIM_W-1:0] MIN_DIM     = DIM_W'(3);
   localparam logic [DIM_W-1:0] MAX_W_DIM   = DIM_W'(MAX_WIDTH);
   localparam logic [DIM_W-1:0] MAX_H_DIM   = DIM_W'(MAX_HEIGHT);
   localparam logic [ROW_W-1:0] ROW_SAT     = {ROW_W{1'b1}};

   // Register indexes
   localparam logic [1:0] REG_LOW    = 2'd0;
   localparam logic [1:0] REG_HIGH   = 2'd1;
   localparam logic [1:0] REG_WIDTH  = 2'd2;
   localparam logic [1:0] REG_HEIGHT = 2'd3;

   // Reset values of the registers
   localparam logic [7:0]       LOW_RESET    = 8'd50;
   localparam logic [7:0]       HIGH_RESET   = 8'd100;
   localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
   localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

   localparam logic [7:0] EDGE_ON = 8'd255;

   // Item kinds in the queue
   localparam logic [1:0] KIND_EMPTY   = 2'd0;
   localparam logic [1:0] KIND_STEP    = 2'd1;
   localparam logic [1:0] KIND_PREFILL = 2'd2;

   // Sector boundaries in quarter degrees
   localparam logic [10:0] ANG_FULL = 11'd1440;
   localparam logic [10:0] ANG_22   = 11'd90;
   localparam logic [10:0] ANG_67   = 11'd270;
   localparam logic [10:0] ANG_112  = 11'd450;
   localparam logic [10:0] ANG_157  = 11'd630;
   localparam logic [10:0] ANG_202  = 11'd810;
   localparam logic [10:0] ANG_247  = 11'd990;
   localparam logic [10:0] ANG_292  = 11'd1170;
   localparam logic [10:0] ANG_337  = 11'd1350;

   localparam logic [1:0] SECT_H    = 2'd0;
   localparam logic [1:0] SECT_DIAG = 2'd1;
   localparam logic [1:0] SECT_V    = 2'd2;
   localparam logic [1:0] SECT_ANTI = 2'd3;

   typedef struct packed {
      logic [7:0]       low;
      logic [7:0]       high;
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
   } cfg_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic [7:0]       mag;
      logic [1:0]       sector;
      logic             wr_mag;
      logic [COL_W-1:0] col;
      logic [1:0]       b0;
      logic [1:0]       b1;
      logic [1:0]       b2;
      logic [COL_W-1:0] s_col;
      logic [1:0]       sb0;
      logic [1:0]       sb1;
      logic [1:0]       sb2;
      logic             s_wr;
      logic             s_int;
      logic             o_valid;
      logic             o_last;
      logic             h_int;
   } item_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

   // Row index modulo three, one row back
   function automatic logic [1:0] mod3_dec(input logic [1:0] x);
      return (x == 2'd0) ? 2'd2 : 2'(x - 2'd1);
   endfunction

   function automatic logic [1:0] mod3_inc(input logic [1:0] x);
      return (x == 2'd2) ? 2'd0 : 2'(x + 2'd1);
   endfunction

   // Quantize gradient direction to one of four compare sectors
   function automatic logic [1:0] angle_sector(input logic [10:0] q_in);
      logic [10:0] q;
      logic [1:0]  s;
      q = (q_in >= ANG_FULL) ? 11'(q_in - ANG_FULL) : q_in;
      if (q <= ANG_22 || (q > ANG_157 && q <= ANG_202) || q > ANG_337) begin
         s = SECT_H;
      end else if ((q > ANG_112 && q <= ANG_157) || (q > ANG_292 && q <= ANG_337)) begin
         s = SECT_DIAG;
      end else if ((q > ANG_67 && q <= ANG_112) || (q > ANG_247 && q <= ANG_292)) begin
         s = SECT_V;
      end else begin
         s = SECT_ANTI;
      end
      return s;
   endfunction

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] maxv);
      logic [DIM_W-1:0] r;
      if (v < MIN_DIM) r = MIN_DIM;
      else if (v > maxv) r = maxv;
      else r = v;
      return r;
   endfunction

endpackage

FILE: rtl/cnh_queue.sv
module cnh_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  cnh_pkg::item_type push_item,
   output logic              head_valid,
   output cnh_pkg::item_type head_item,
   input  logic              pop
);
   import cnh_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;

   assign push_ready = (count_ff != 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_item  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !pop) count_in = 2'(count_ff + 2'd1);
      else if (!do_push && pop) count_in = 2'(count_ff - 2'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_item;
   end

endmodule

FILE: rtl/cnh_front.sv
module cnh_front (
   input  logic                     clock,
   input  logic                     reset,
   input  cnh_pkg::cfg_type         cfg,
   input  logic                     csr_wr,
   input  cnh_pkg::back_status_type back_status,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [23:0]              req_tdata,
   input  logic                     req_tuser,
   output logic                     q_valid,
   input  logic                     q_ready,
   output cnh_pkg::item_type        q_item
);
   import cnh_pkg::*;

   localparam logic [1:0] ST_RUN  = 2'd0;
   localparam logic [1:0] ST_NORM = 2'd1;
   localparam logic [1:0] ST_PF1  = 2'd2;
   localparam logic [1:0] ST_PF2  = 2'd3;

   logic [1:0]       st_ff, st_in;
   logic             pend_ff, pend_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [1:0]       rm_ff, rm_in;
   // position as left by the last step, before any realignment
   logic [ROW_W-1:0] brow_ff, brow_in;
   logic [COL_W-1:0] bcol_ff, bcol_in;
   logic [1:0]       brm_ff, brm_in;

   logic [DIM_W-1:0] w, h;
   logic             in_frame, beyond, flush, restart, do_step, accept;
   logic [ROW_W-1:0] r0, r1, r2;
   logic [COL_W-1:0] c0, c1, c2, w_last;
   logic [1:0]       rm0, rm1;
   logic             c0_nz, c1_nz, m1_ex, m2_ex;
   logic             run_ok;

   assign w      = cfg.width;
   assign h      = cfg.height;
   assign flush  = req_tuser;
   assign w_last = COL_W'(w - DIM_W'(1));

   // Where the stream stands relative to the frame and its drain tail
   assign in_frame = (row_ff < h);
   assign beyond   = (row_ff > 11'(h + 11'd2)) ||
                     ((row_ff == 11'(h + 11'd2)) && (col_ff >= COL_W'(2)));
   assign restart  = (st_ff == ST_RUN) && !flush && !in_frame;
   assign do_step  = !flush || (!in_frame && !beyond);

   assign r0  = restart ? '0 : row_ff;
   assign c0  = restart ? '0 : col_ff;
   assign rm0 = restart ? 2'd0 : rm_ff;

   // Suppression center: w+1 positions back
   assign c0_nz = (c0 != '0);
   assign r1    = c0_nz ? ROW_W'(r0 - 11'd1) : ROW_W'(r0 - 11'd2);
   assign c1    = c0_nz ? COL_W'(c0 - 10'd1) : w_last;
   assign rm1   = c0_nz ? mod3_dec(rm0) : mod3_dec(mod3_dec(rm0));
   assign m1_ex = (r0 >= 11'd2) || ((r0 == 11'd1) && c0_nz);

   // Hysteresis center: another w+1 positions back
   assign c1_nz = (c1 != '0);
   assign r2    = c1_nz ? ROW_W'(r1 - 11'd1) : ROW_W'(r1 - 11'd2);
   assign c2    = c1_nz ? COL_W'(c1 - 10'd1) : w_last;
   assign m2_ex = m1_ex && ((r1 >= 11'd2) || ((r1 == 11'd1) && c1_nz));

   // Item build; an ignored flush carries an empty result
   always_comb begin
      q_item        = '0;
      q_item.mag    = req_tdata[7:0];
      q_item.sector = angle_sector(req_tdata[18:8]);
      q_item.wr_mag = (r0 < h);
      q_item.b0     = rm0;
      q_item.b1     = mod3_dec(rm0);
      q_item.b2     = mod3_dec(mod3_dec(rm0));
      q_item.sb0    = rm1;
      q_item.sb1    = mod3_dec(rm1);
      q_item.sb2    = mod3_dec(mod3_dec(rm1));
      q_item.s_wr   = m1_ex && (r1 < h);
      q_item.s_int  = (r1 != '0) && (c1 != '0) && (11'(r1 + 11'd1) < h) &&
                      (11'({1'b0, c1} + 11'd1) < w);
      q_item.o_valid = do_step && m2_ex && (r2 < h);
      q_item.o_last  = (r2 == 11'(h - 11'd1)) && (c2 == w_last);
      q_item.h_int   = (r2 != '0) && (c2 != '0) && (11'(r2 + 11'd1) < h) &&
                       (11'({1'b0, c2} + 11'd1) < w);
      unique case (st_ff)
         ST_PF1: begin
            q_item.kind  = KIND_PREFILL;
            q_item.col   = COL_W'(c0 - 10'd2);
            q_item.s_col = COL_W'(c1 - 10'd2);
         end
         ST_PF2: begin
            q_item.kind  = KIND_PREFILL;
            q_item.col   = COL_W'(c0 - 10'd1);
            q_item.s_col = COL_W'(c1 - 10'd1);
         end
         default: begin
            q_item.kind  = do_step ? KIND_STEP : KIND_EMPTY;
            q_item.col   = c0;
            q_item.s_col = c1;
         end
      endcase
   end

   // Handshake
   assign run_ok     = (st_ff == ST_RUN) && !pend_ff && !back_status.clearing;
   assign req_tready = run_ok && q_ready;
   assign accept     = req_tvalid && req_tready;
   assign q_valid    = (st_ff == ST_RUN) ? (req_tvalid && run_ok) :
                       ((st_ff == ST_PF1) || (st_ff == ST_PF2));

   // Position tracking, realignment after a register write
   always_comb begin
      st_in   = st_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      rm_in   = rm_ff;
      brow_in = brow_ff;
      bcol_in = bcol_ff;
      brm_in  = brm_ff;
      pend_in = csr_wr || (pend_ff && (st_ff != ST_RUN));
      unique case (st_ff)
         ST_RUN: begin
            if (pend_ff) begin
               // realign from the last stepped position, not a prior realignment
               st_in  = ST_NORM;
               row_in = brow_ff;
               col_in = bcol_ff;
               rm_in  = brm_ff;
            end else if (accept && do_step) begin
               if (11'({1'b0, c0} + 11'd1) == w) begin
                  col_in = '0;
                  row_in = (r0 == ROW_SAT) ? r0 : ROW_W'(r0 + 11'd1);
                  rm_in  = mod3_inc(rm0);
               end else begin
                  col_in = COL_W'(c0 + 10'd1);
                  row_in = r0;
                  rm_in  = rm0;
               end
               brow_in = row_in;
               bcol_in = col_in;
               brm_in  = rm_in;
            end
         end
         ST_NORM: begin
            if ({1'b0, col_ff} >= w) begin
               col_in = COL_W'({1'b0, col_ff} - w);
               row_in = (row_ff == ROW_SAT) ? row_ff : ROW_W'(row_ff + 11'd1);
               rm_in  = mod3_inc(rm_ff);
            end else begin
               st_in = ST_PF1;
            end
         end
         ST_PF1: begin
            if (q_ready) st_in = ST_PF2;
         end
         ST_PF2: begin
            if (q_ready) st_in = ST_RUN;
         end
         default: st_in = ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_RUN;
         pend_ff <= 1'b0;
         row_ff  <= '0;
         col_ff  <= '0;
         rm_ff   <= 2'd0;
         brow_ff <= '0;
         bcol_ff <= '0;
         brm_ff  <= 2'd0;
      end else begin
         st_ff   <= st_in;
         pend_ff <= pend_in;
         row_ff  <= row_in;
         col_ff  <= col_in;
         rm_ff   <= rm_in;
         brow_ff <= brow_in;
         bcol_ff <= bcol_in;
         brm_ff  <= brm_in;
      end
   end

endmodule

FILE: rtl/cnh_back.sv
module cnh_back (
   input  logic                     clock,
   input  logic                     reset,
   input  cnh_pkg::cfg_type         cfg,
   input  logic                     head_valid,
   input  cnh_pkg::item_type        head_item,
   output logic                     pop,
   output cnh_pkg::back_status_type back_status,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [15:0]              rsp_tdata,
   output logic                     rsp_tlast
);
   import cnh_pkg::*;

   localparam int MEM_DEPTH = MAX_WIDTH;

   // Row banks, one per row modulo three
   logic [7:0] mag_mem [BANKS][MEM_DEPTH];
   logic [1:0] sec_mem [BANKS][MEM_DEPTH];
   logic [7:0] sup_mem [BANKS][MEM_DEPTH];

   logic [7:0] mag_rd_ff [BANKS];
   logic [1:0] sec_rd_ff [BANKS];
   logic [7:0] sup_rd_ff [BANKS];

   logic [COL_W:0]   clr_ff, clr_in;
   logic             clearing, adv;

   logic             p1_vld_ff, p2_vld_ff;
   item_type         p1_item_ff, p2_item_ff;
   logic [7:0]       p2_sval_ff, sval;

   logic [7:0]       mwin_ff [2][3];
   logic [7:0]       hwin_ff [2][3];
   logic [1:0]       sec_prev_ff;
   logic [7:0]       mnew [3];
   logic [7:0]       hnew [3];

   logic             mag_we [BANKS];
   logic             sup_we [BANKS];
   logic [COL_W-1:0] mag_wa, sup_wa;
   logic [7:0]       mag_wd, sup_wd;
   logic [1:0]       sec_wd;

   logic             rsp_valid_ff;
   logic [7:0]       rsp_edge_ff, edge_val;
   logic             rsp_ov_ff, rsp_last_ff;

   logic [7:0]       na, nb, mc, hc;
   logic             strong_any, hyst_on;
   logic             m_shift, h_shift;

   assign clearing             = !clr_ff[COL_W];
   assign back_status.clearing = clearing;
   assign adv                  = !rsp_valid_ff || rsp_tready;
   assign pop                  = adv && head_valid && !clearing;

   // Clearing sweep after reset
   assign clr_in = clearing ? (COL_W+1)'(clr_ff + 1'b1) : clr_ff;

   // Bank write controls
   always_comb begin
      mag_wa = clearing ? clr_ff[COL_W-1:0] : head_item.col;
      mag_wd = clearing ? 8'd0 : head_item.mag;
      sec_wd = clearing ? 2'd0 : head_item.sector;
      sup_wa = clearing ? clr_ff[COL_W-1:0] : p2_item_ff.s_col;
      sup_wd = clearing ? 8'd0 : p2_sval_ff;
      for (int b = 0; b < BANKS; b++) begin
         mag_we[b] = clearing || (pop && (head_item.kind == KIND_STEP) &&
                     head_item.wr_mag && (head_item.b0 == 2'(b)));
         sup_we[b] = clearing || (adv && p2_vld_ff && (p2_item_ff.kind == KIND_STEP) &&
                     p2_item_ff.s_wr && (p2_item_ff.sb0 == 2'(b)));
      end
   end

   always_ff @(posedge clock) begin
      for (int b = 0; b < BANKS; b++) begin
         if (mag_we[b]) begin
            mag_mem[b][mag_wa] <= mag_wd;
            sec_mem[b][mag_wa] <= sec_wd;
         end
         if (adv) begin
            mag_rd_ff[b] <= mag_mem[b][head_item.col];
            sec_rd_ff[b] <= sec_mem[b][head_item.col];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int b = 0; b < BANKS; b++) begin
         if (sup_we[b]) sup_mem[b][sup_wa] <= sup_wd;
         if (adv) sup_rd_ff[b] <= sup_mem[b][p1_item_ff.s_col];
      end
   end

   // Stage 1: new magnitude column and suppression compare
   always_comb begin
      mnew[0] = mag_rd_ff[p1_item_ff.b2];
      mnew[1] = mag_rd_ff[p1_item_ff.b1];
      mnew[2] = (p1_item_ff.kind == KIND_PREFILL) ? mag_rd_ff[p1_item_ff.b0] :
                p1_item_ff.mag;
      mc = mwin_ff[1][1];
      case (sec_prev_ff)
         SECT_H: begin
            na = mwin_ff[0][1];
            nb = mnew[1];
         end
         SECT_DIAG: begin
            na = mwin_ff[0][0];
            nb = mnew[2];
         end
         SECT_V: begin
            na = mwin_ff[1][0];
            nb = mwin_ff[1][2];
         end
         default: begin
            na = mwin_ff[0][2];
            nb = mnew[0];
         end
      endcase
      sval = (p1_item_ff.s_int && (mc > na) && (mc > nb)) ? mc : 8'd0;
   end

   assign m_shift = adv && p1_vld_ff && (p1_item_ff.kind != KIND_EMPTY);

   always_ff @(posedge clock) begin
      if (m_shift) begin
         for (int r = 0; r < 3; r++) begin
            mwin_ff[0][r] <= mwin_ff[1][r];
            mwin_ff[1][r] <= mnew[r];
         end
         sec_prev_ff <= sec_rd_ff[p1_item_ff.b1];
      end
   end

   // Stage 2: new suppressed column and hysteresis
   always_comb begin
      hnew[0] = sup_rd_ff[p2_item_ff.sb2];
      hnew[1] = sup_rd_ff[p2_item_ff.sb1];
      hnew[2] = (p2_item_ff.kind == KIND_PREFILL) ? sup_rd_ff[p2_item_ff.sb0] :
                p2_sval_ff;
      hc = hwin_ff[1][1];
      strong_any = 1'b0;
      for (int r = 0; r < 3; r++) begin
         strong_any = strong_any || (hwin_ff[0][r] > cfg.high) ||
                      (hwin_ff[1][r] > cfg.high) || (hnew[r] > cfg.high);
      end
      hyst_on  = p2_item_ff.h_int &&
                 ((hc > cfg.high) || ((hc >= cfg.low) && strong_any));
      edge_val = (p2_item_ff.o_valid && hyst_on) ? EDGE_ON : 8'd0;
   end

   assign h_shift = adv && p2_vld_ff && (p2_item_ff.kind != KIND_EMPTY);

   always_ff @(posedge clock) begin
      if (h_shift) begin
         for (int r = 0; r < 3; r++) begin
            hwin_ff[0][r] <= hwin_ff[1][r];
            hwin_ff[1][r] <= hnew[r];
         end
      end
   end

   // Pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         p1_vld_ff    <= 1'b0;
         p2_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff <= clr_in;
         if (adv) begin
            p1_vld_ff    <= pop;
            p2_vld_ff    <= p1_vld_ff;
            rsp_valid_ff <= p2_vld_ff && (p2_item_ff.kind != KIND_PREFILL);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_item_ff  <= head_item;
         p2_item_ff  <= p1_item_ff;
         p2_sval_ff  <= sval;
         rsp_edge_ff <= edge_val;
         rsp_ov_ff   <= p2_item_ff.o_valid;
         rsp_last_ff <= p2_item_ff.o_valid && p2_item_ff.o_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ov_ff, rsp_edge_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: rtl/canny_nms_hysteresis.sv
// Streaming Canny edge stage: non-maximum suppression over a 3x3 window along the
// quantized gradient direction, then hysteresis over a second 3x3 window. One pixel
// beat is taken per clock unless back-pressure, clearing or realignment holds
// req_tready low, and every input beat yields exactly one result beat; the result
// for frame pixel p leaves with input beat p + 2*width + 2, so a frame is drained
// by 2*width + 2 flush beats (tuser high). Each beat passes through the queue, the
// bank read with suppression and the hysteresis stage into the result register.
// After reset a clearing pass over the 1024-entry row banks holds req_tready low.
// After each register write the stream position is realigned to the new geometry,
// one row per clock, then the windows refill from the banks, req_tready still low.
module canny_nms_hysteresis (
   input  logic        clock,
   input  logic        reset,
   // input pixels
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] magnitude, [18:8] angle_quarter_deg
   input  logic        req_tuser,   // flush
   // results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] edge_value, [8] out_valid
   output logic        rsp_tlast,   // frame_last
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_data
);
   import cnh_pkg::*;

   cfg_type         cfg_ff, cfg_in;
   back_status_type back_status;
   logic            csr_wr;
   logic            q_in_valid, q_in_ready, q_head_valid, q_pop;
   item_type        q_in_item, q_head_item;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   // Register file; geometry is stored already clamped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_index)
            REG_LOW:    cfg_in.low    = csr_data[7:0];
            REG_HIGH:   cfg_in.high   = csr_data[7:0];
            REG_WIDTH:  cfg_in.width  = clamp_dim(csr_data, MAX_W_DIM);
            REG_HEIGHT: cfg_in.height = clamp_dim(csr_data, MAX_H_DIM);
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low    <= LOW_RESET;
         cfg_ff.high   <= HIGH_RESET;
         cfg_ff.width  <= WIDTH_RESET;
         cfg_ff.height <= HEIGHT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cnh_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .csr_wr      (csr_wr),
      .back_status (back_status),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .q_valid     (q_in_valid),
      .q_ready     (q_in_ready),
      .q_item      (q_in_item)
   );

   cnh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_in_valid),
      .push_ready (q_in_ready),
      .push_item  (q_in_item),
      .head_valid (q_head_valid),
      .head_item  (q_head_item),
      .pop        (q_pop)
   );

   cnh_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .head_valid  (q_head_valid),
      .head_item   (q_head_item),
      .pop         (q_pop),
      .back_status (back_status),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

FILE: test/canny_nms_checker.sv
module canny_nms_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_data,
   output int          mismatches,
   output int          edges_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import cnh_pkg::*;

   typedef struct packed {
      logic [7:0] edge_value;
      logic       out_valid;
      logic       frame_last;
   } edge_beat_type;

   edge_beat_type expected_edges[$];

   // shadow of the block registers and line stores
   logic [7:0]  low_thr, high_thr;
   logic [10:0] width_reg, height_reg;
   logic [7:0]  mag_rows[3][MAX_WIDTH];
   logic [1:0]  dir_rows[3][MAX_WIDTH];
   logic [7:0]  thin_rows[3][MAX_WIDTH];
   int unsigned pos_row, pos_col;

   function automatic int unsigned clip_dim(input logic [10:0] v, input int unsigned lim);
      if (v < 3) return 3;
      if (v > lim) return lim;
      return v;
   endfunction

   function automatic logic [1:0] direction_of(input logic [10:0] q_in);
      int unsigned q;
      q = (q_in >= 1440) ? q_in - 1440 : q_in;
      if (q <= 90 || (q > 630 && q <= 810) || q > 1350) return SECT_H;
      if ((q > 450 && q <= 630) || (q > 1170 && q <= 1350)) return SECT_DIAG;
      if ((q > 270 && q <= 450) || (q > 990 && q <= 1170)) return SECT_V;
      return SECT_ANTI;
   endfunction

   function automatic logic [7:0] thin_at(input int unsigned r, c, w, h);
      logic [7:0]  m, a, b;
      int unsigned rp, rn;
      if (r == 0 || c == 0 || r + 1 >= h || c + 1 >= w) return 0;
      rp = (r - 1) % 3;
      rn = (r + 1) % 3;
      m = mag_rows[r % 3][c];
      case (dir_rows[r % 3][c])
         SECT_H: begin
            a = mag_rows[r % 3][c - 1]; b = mag_rows[r % 3][c + 1];
         end
         SECT_DIAG: begin
            a = mag_rows[rp][c - 1]; b = mag_rows[rn][c + 1];
         end
         SECT_V: begin
            a = mag_rows[rp][c]; b = mag_rows[rn][c];
         end
         default: begin
            a = mag_rows[rn][c - 1]; b = mag_rows[rp][c + 1];
         end
      endcase
      return (m > a && m > b) ? m : 8'd0;
   endfunction

   function automatic logic [7:0] link_at(input int unsigned r, c, w, h);
      logic [7:0] s;
      if (r == 0 || c == 0 || r + 1 >= h || c + 1 >= w) return 0;
      s = thin_rows[r % 3][c];
      if (s > high_thr) return EDGE_ON;
      if (s < low_thr) return 0;
      for (int unsigned x = r - 1; x <= r + 1; x++)
         for (int unsigned y = c - 1; y <= c + 1; y++)
            if (thin_rows[x % 3][y] > high_thr) return EDGE_ON;
      return 0;
   endfunction

   // advance the shadow by one pixel beat and return the edge beat it releases
   function automatic edge_beat_type advance_pixel(input logic [7:0] mag,
                                                   input logic [10:0] q,
                                                   input logic fl);
      edge_beat_type res;
      int unsigned   w, h, total, lat, n, m1, m2;
      res = '0;
      w = clip_dim(width_reg, MAX_WIDTH);
      h = clip_dim(height_reg, MAX_HEIGHT);
      total = w * h;
      lat = 2 * w + 2;
      n = pos_row * w + pos_col;
      if (!fl) begin
         if (n >= total) n = 0;
      end else if (n < total || n >= total + lat) begin
         return res;
      end
      if (n < total) begin
         mag_rows[(n / w) % 3][n % w] = mag;
         dir_rows[(n / w) % 3][n % w] = direction_of(q);
      end
      if (n >= w + 1) begin
         m1 = n - (w + 1);
         if (m1 < total) thin_rows[(m1 / w) % 3][m1 % w] = thin_at(m1 / w, m1 % w, w, h);
      end
      if (n >= lat) begin
         m2 = n - lat;
         if (m2 < total) begin
            res.edge_value = link_at(m2 / w, m2 % w, w, h);
            res.out_valid = 1'b1;
            res.frame_last = (m2 + 1 == total);
         end
      end
      n++;
      pos_row = n / w;
      pos_col = n % w;
      return res;
   endfunction

   always @(posedge clock) begin
      edge_beat_type want;
      if (reset) begin
         low_thr = LOW_RESET;
         high_thr = HIGH_RESET;
         width_reg = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         pos_row = 0;
         pos_col = 0;
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < MAX_WIDTH; j++) begin
               mag_rows[i][j] = 0; dir_rows[i][j] = 0; thin_rows[i][j] = 0;
            end
         expected_edges.delete();
         mismatches = 0;
      end else begin
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_LOW:    low_thr = csr_data[7:0];
               REG_HIGH:   high_thr = csr_data[7:0];
               REG_WIDTH:  width_reg = csr_data;
               REG_HEIGHT: height_reg = csr_data;
               default: ;
            endcase
         end
         // result beat against the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            if (expected_edges.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result beat: edge %0d valid %0b last %0b",
                           rsp_tdata[7:0], rsp_tdata[8], rsp_tlast);
            end else begin
               want = expected_edges.pop_front();
               if (rsp_tdata[7:0] !== want.edge_value || rsp_tdata[8] !== want.out_valid ||
                   rsp_tlast !== want.frame_last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result mismatch: expected edge %0d valid %0b last %0b, got %0d %0b %0b",
                              want.edge_value, want.out_valid, want.frame_last,
                              rsp_tdata[7:0], rsp_tdata[8], rsp_tlast);
               end
            end
         end
         // pixel beat: predict its result
         if (req_tvalid && req_tready)
            expected_edges.push_back(advance_pixel(req_tdata[7:0], req_tdata[18:8], req_tuser));
      end
      edges_pending = expected_edges.size();
   end

endmodule

FILE: test/canny_nms_hysteresis_tb.sv
module canny_nms_hysteresis_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cnh_pkg::*;

   localparam int STALL_LIMIT = 20000;

   // sector boundary angles, each side of every edge plus out-of-range values
   localparam logic [10:0] ANGLES [20] = '{0, 90, 91, 270, 271, 450, 451, 630, 631, 810,
                                           811, 990, 991, 1170, 1171, 1350, 1351, 1439,
                                           1440, 2047};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [10:0] csr_data = '0;
   int          mismatches, edges_pending;
   int          pixels_sent = 0;
   int          tx_idle_pct = 9, rx_idle_pct = 60;
   int          stall_cycles = 0;

   canny_nms_hysteresis uut (.*);
   canny_nms_checker chk (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // receiver back-pressure
   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= rx_idle_pct);

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else if (stall_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end else
         stall_cycles <= stall_cycles + 1;
   end

   task automatic send_beat(input logic [7:0] mag, input logic [10:0] ang, input logic fl);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'd0, ang, mag};
      req_tuser <= fl;
      do @(posedge clock); while (!req_tready);
      if (!fl) pixels_sent++;
      // idling schedule: receiver idles first, then sender, then neither
      if (pixels_sent < 140) begin
         tx_idle_pct = 9; rx_idle_pct = 60;
      end else if (pixels_sent < 280) begin
         tx_idle_pct = 60; rx_idle_pct = 9;
      end else begin
         tx_idle_pct = 0; rx_idle_pct = 0;
      end
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // hold the stream until every expected result has come back
   task automatic drain_all();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (edges_pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic run_frame(input int w, input int h, input bit broken);
      int npix;
      npix = broken ? $urandom_range(w * h - 1, 1) : w * h;
      for (int p = 0; p < npix; p++) begin
         // stray flush inside the frame is ignored
         if ($urandom_range(99) < 5)
            send_beat(8'($urandom), 11'($urandom), 1'b1);
         send_beat($urandom_range(3) == 0 ? 8'($urandom_range(255, 200)) : 8'($urandom),
                   11'($urandom_range(2047)), 1'b0);
      end
      for (int f = 0; f < 2 * w + 3; f++)
         send_beat(8'($urandom), 11'($urandom), 1'b1);
   endtask

   initial begin
      int w, h;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: angle sector boundaries at reset geometry
      for (int i = 0; i < 20; i++)
         send_beat((i % 2) ? 8'hFF : 8'h00, ANGLES[i], 1'b0);
      send_beat(8'h55, 11'h2AA, 1'b1);
      drain_all();

      // directed: tiny frames at threshold extremes, then with low above high
      write_reg(REG_LOW, 11'd0);
      write_reg(REG_HIGH, 11'd255);
      write_reg(REG_WIDTH, 11'd0);
      write_reg(REG_HEIGHT, 11'd2);
      run_frame(3, 3, 1'b0);
      drain_all();
      write_reg(REG_LOW, 11'd255);
      write_reg(REG_HIGH, 11'd0);
      write_reg(REG_WIDTH, 11'd3);
      write_reg(REG_HEIGHT, 11'd3);
      run_frame(3, 3, 1'b0);
      drain_all();

      // largest geometries: a partial wide row, then a tall frame that picks it up
      write_reg(REG_LOW, 11'd40);
      write_reg(REG_HIGH, 11'd180);
      write_reg(REG_WIDTH, 11'd2047);
      write_reg(REG_HEIGHT, 11'd3);
      for (int p = 0; p < 60; p++)
         send_beat(8'($urandom), 11'($urandom_range(2047)), 1'b0);
      drain_all();
      write_reg(REG_WIDTH, 11'd3);
      write_reg(REG_HEIGHT, 11'd2047);
      for (int p = 0; p < 40; p++)
         send_beat(8'($urandom), 11'($urandom_range(2047)), 1'b0);
      drain_all();

      // random small frames with varied settings
      while (pixels_sent < 420) begin
         w = $urandom_range(8, 3);
         h = $urandom_range(6, 3);
         write_reg(REG_LOW, 11'($urandom_range(255)));
         write_reg(REG_HIGH, 11'($urandom_range(255)));
         write_reg(REG_WIDTH, 11'(w));
         write_reg(REG_HEIGHT, 11'(h));
         repeat ($urandom_range(3, 1)) run_frame(w, h, $urandom_range(9) == 0);
         drain_all();
      end

      drain_all();
      if (mismatches == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule

FILE: sim.f
rtl/cnh_pkg.sv
rtl/cnh_queue.sv
rtl/cnh_front.sv
rtl/cnh_back.sv
rtl/canny_nms_hysteresis.sv
test/canny_nms_checker.sv
test/canny_nms_hysteresis_tb.sv
